// ===== hdl/adaptive_mode_cpu_scheduler_top_macros.svh =====
// Assertion macros for the adaptive mode cpu scheduler checker.
// Depends on nothing; included by the checker file only.
`ifndef ADAPTIVE_MODE_CPU_SCHEDULER_TOP_MACROS_SVH
`define ADAPTIVE_MODE_CPU_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define AMCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amcs check failed: same-cycle rule");

// Next-cycle implication, reset masks the check.
`define AMCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amcs check failed: next-cycle rule");

`endif

// ===== hdl/amcs_pkg.sv =====
// Shared types and constants for the adaptive mode cpu scheduler.
// No dependencies; used by the top level and the checker.
package amcs_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int IW  = $clog2(TABLE_DEPTH + 1);
  localparam int NW  = $clog2(TABLE_DEPTH + 2);
  localparam int SW  = 16 + NW;
  localparam int QW  = 32 + NW;
  localparam int IOW = 7 + NW;
  localparam int PW  = 32 + 2 * NW;
  localparam int DW  = PW + 5;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_RR   = 2'd2;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_DISPATCH = 2'd1;
  localparam logic [1:0] EV_PREEMPT  = 2'd2;
  localparam logic [1:0] EV_ROTATE   = 2'd3;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [1:0] CFG_IO_CUTOFF  = 2'd0;
  localparam logic [1:0] CFG_HOLD_TICKS = 2'd1;
  localparam logic [1:0] CFG_TIME_SLICE = 2'd2;

  localparam logic [6:0]  IO_CUTOFF_RST  = 7'd15;
  localparam logic [15:0] HOLD_TICKS_RST = 16'd250;
  localparam logic [15:0] TIME_SLICE_RST = 16'd10;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arrival;
    logic [15:0] length;
    logic [6:0]  io;
  } job_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] job_id;
    logic [31:0] job_arrival;
    logic [15:0] job_length;
    logic [6:0]  job_io_percent;
    logic [31:0] now;
    logic        running_valid;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  event_res;
    logic        out_valid;
    logic [15:0] out_id;
    logic [31:0] out_arrival;
    logic [15:0] out_length;
    logic [6:0]  out_io_percent;
    logic        table_full;
  } out_item_t;

endpackage

// ===== hdl/adaptive_mode_cpu_scheduler_top.sv =====
// Adaptive mode cpu scheduler: ready table in a synchronous memory plus policy logic.
// Depends on amcs_pkg.
//
// Usage:
//  - Input beat: in_data is taken at a clock edge with start high and busy low.
//    An enqueue stores the job in the lowest free slot (or flags table_full).
//    A tick carries the running job and re-runs policy selection and dispatch.
//  - Result beat: out_data is valid for exactly one cycle while out_strobe is
//    high. There is no back-pressure; the receiver must take it then.
//  - Config: cfg_valid with cfg_ready (always high) writes register cfg_index.
//    Write only while busy is low and no result is pending.
//  - Timing: an enqueue answers in the cycle after acceptance and busy stays low.
//    A tick walks the ready table once through the single memory read port,
//    then forms the candidate mode in turn (products, difference, compare).
//    A tick with a finish, idle or rotation walks the table a second time.
//    The read port limits each walk to one table entry per cycle.
//  - Reset clears the valid bits, mode (fcfs), hold window origin, slice
//    counter and the config registers to their defaults. Memory contents are
//    not cleared; an entry is only used while its valid bit is set.
module adaptive_mode_cpu_scheduler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  amcs_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output amcs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_SCNX = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_PRE  = 4'd6;
  localparam logic [3:0] S_BR   = 4'd7;
  localparam logic [3:0] S_ACT  = 4'd8;

  localparam int D  = amcs_pkg::TABLE_DEPTH;
  localparam int AW = amcs_pkg::AW;
  localparam int IW = amcs_pkg::IW;
  localparam int NW = amcs_pkg::NW;
  localparam int SW = amcs_pkg::SW;
  localparam int QW = amcs_pkg::QW;
  localparam int IOW = amcs_pkg::IOW;
  localparam int PW = amcs_pkg::PW;
  localparam int DW = amcs_pkg::DW;

  // Ready table storage: one job record per slot.
  amcs_pkg::job_t mem [D];
  amcs_pkg::job_t rd_data_r;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  amcs_pkg::job_t mem_wd;

  // Control state.
  logic [3:0]  state_r, state_nxt;
  logic [6:0]  io_cutoff_r, io_cutoff_nxt;
  logic [15:0] hold_ticks_r, hold_ticks_nxt;
  logic [15:0] time_slice_r, time_slice_nxt;
  logic [D-1:0] valid_r, valid_nxt;
  logic [1:0]  cur_mode_r, cur_mode_nxt;
  logic [31:0] last_change_r, last_change_nxt;
  logic [15:0] slice_r, slice_nxt;
  logic        out_strobe_r, out_strobe_nxt;
  logic [AW:0] cnt_r, cnt_nxt;
  logic        pipe_v_r, pipe_v_nxt;

  // Per-tick working state.
  logic        run_r, run_nxt;
  amcs_pkg::job_t job_r, job_nxt;
  logic [31:0] now_r, now_nxt;
  logic [1:0]  event_r, event_nxt;
  logic        full_r, full_nxt;
  logic        pass_r, pass_nxt;
  logic        xstat_r, xstat_nxt;
  logic        xpick_r, xpick_nxt;
  logic        rotate_r, rotate_nxt;
  logic [AW-1:0] pipe_idx_r, pipe_idx_nxt;

  // Scan accumulators and mode arithmetic.
  logic           any_r, any_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  logic [IOW-1:0] sio_r, sio_nxt;
  logic [SW-1:0]  s_r, s_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  logic           lfound_r, lfound_nxt;
  logic [IW-1:0]  lidx_r, lidx_nxt;
  amcs_pkg::job_t ljob_r, ljob_nxt;
  logic           afound_r, afound_nxt;
  logic [IW-1:0]  aidx_r, aidx_nxt;
  amcs_pkg::job_t ajob_r, ajob_nxt;
  logic [PW-1:0]  nq_r, nq_nxt;
  logic [PW-1:0]  ss_r, ss_nxt;
  logic [PW-1:0]  dev_r, dev_nxt;
  logic           iorr_r, iorr_nxt;

  amcs_pkg::out_item_t out_r, out_nxt;

  // Lowest free slot.
  logic          free_found;
  logic [AW-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;
  assign rd_addr    = cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    logic           emit;
    logic           p_en;
    logic           p_stat;
    logic           p_pick;
    amcs_pkg::job_t p_job;
    logic [IW-1:0]  p_idx;
    logic [1:0]     cand;
    logic           pk_found;
    logic [IW-1:0]  pk_idx;
    amcs_pkg::job_t pk_job;
    logic [DW-1:0]  dev_w;
    logic [DW-1:0]  ss_w;

    state_nxt       = state_r;
    io_cutoff_nxt   = io_cutoff_r;
    hold_ticks_nxt  = hold_ticks_r;
    time_slice_nxt  = time_slice_r;
    valid_nxt       = valid_r;
    cur_mode_nxt    = cur_mode_r;
    last_change_nxt = last_change_r;
    slice_nxt       = slice_r;
    out_strobe_nxt  = 1'b0;
    cnt_nxt         = cnt_r;
    pipe_v_nxt      = 1'b0;
    pipe_idx_nxt    = cnt_r[AW-1:0];
    run_nxt         = run_r;
    job_nxt         = job_r;
    now_nxt         = now_r;
    event_nxt       = event_r;
    full_nxt        = full_r;
    pass_nxt        = pass_r;
    xstat_nxt       = xstat_r;
    xpick_nxt       = xpick_r;
    rotate_nxt      = rotate_r;
    any_nxt         = any_r;
    n_nxt           = n_r;
    sio_nxt         = sio_r;
    s_nxt           = s_r;
    q_nxt           = q_r;
    lfound_nxt      = lfound_r;
    lidx_nxt        = lidx_r;
    ljob_nxt        = ljob_r;
    afound_nxt      = afound_r;
    aidx_nxt        = aidx_r;
    ajob_nxt        = ajob_r;
    nq_nxt          = nq_r;
    ss_nxt          = ss_r;
    dev_nxt         = dev_r;
    iorr_nxt        = iorr_r;
    out_nxt         = out_r;
    mem_we          = 1'b0;
    mem_wa          = '0;
    mem_wd          = job_r;
    emit            = 1'b0;
    p_en            = 1'b0;
    p_stat          = 1'b0;
    p_pick          = 1'b0;
    p_job           = rd_data_r;
    p_idx           = IW'(pipe_idx_r);
    cand            = amcs_pkg::POL_FCFS;
    pk_found        = 1'b0;
    pk_idx          = '0;
    pk_job          = ajob_r;
    dev_w           = DW'(dev_r);
    ss_w            = DW'(ss_r);

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        amcs_pkg::CFG_IO_CUTOFF:  io_cutoff_nxt  = cfg_data[6:0];
        amcs_pkg::CFG_HOLD_TICKS: hold_ticks_nxt = cfg_data;
        amcs_pkg::CFG_TIME_SLICE: time_slice_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.opcode == amcs_pkg::OP_ENQUEUE) begin
            // Store the job, answer next cycle.
            mem_wd.id      = in_data.job_id;
            mem_wd.arrival = in_data.job_arrival;
            mem_wd.length  = in_data.job_length;
            mem_wd.io      = in_data.job_io_percent;
            if (free_found) begin
              mem_we              = 1'b1;
              mem_wa              = free_idx;
              valid_nxt[free_idx] = 1'b1;
              full_nxt            = 1'b0;
            end else begin
              full_nxt = 1'b1;
            end
            run_nxt   = 1'b0;
            event_nxt = amcs_pkg::EV_NONE;
            emit      = 1'b1;
          end else begin
            job_nxt.id      = in_data.job_id;
            job_nxt.arrival = in_data.job_arrival;
            job_nxt.length  = in_data.job_length;
            job_nxt.io      = in_data.job_io_percent;
            now_nxt         = in_data.now;
            run_nxt         = in_data.running_valid;
            event_nxt       = amcs_pkg::EV_NONE;
            full_nxt        = 1'b0;
            if (in_data.running_valid && slice_r != 16'hFFFF) begin
              slice_nxt = slice_r + 16'd1;
            end
            pass_nxt  = 1'b0;
            xstat_nxt = in_data.running_valid;
            xpick_nxt = 1'b0;
            rotate_nxt = 1'b0;
            state_nxt = S_SCAN;
            cnt_nxt   = '0;
            any_nxt = 1'b0; n_nxt = '0; sio_nxt = '0; s_nxt = '0; q_nxt = '0;
            lfound_nxt = 1'b0; afound_nxt = 1'b0;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle, fold in the entry read last cycle.
        if (cnt_r < (AW+1)'(D)) begin
          pipe_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end else begin
          state_nxt = S_SCNX;
        end
        p_en   = pipe_v_r && valid_r[pipe_idx_r];
        p_stat = 1'b1;
        p_pick = 1'b1;
      end

      S_SCNX: begin
        // Running job joins after all slots.
        p_en      = xstat_r || xpick_r;
        p_stat    = xstat_r;
        p_pick    = xpick_r;
        p_job     = job_r;
        p_idx     = IW'(D);
        state_nxt = S_M1;
      end

      S_M1: begin
        nq_nxt = PW'(n_r) * PW'(q_r);
        ss_nxt = PW'(s_r) * PW'(s_r);
        if (n_r == '0) begin
          iorr_nxt = (io_cutoff_r == 7'd0);
        end else begin
          iorr_nxt = (sio_r >= IOW'(io_cutoff_r) * IOW'(n_r));
        end
        state_nxt = S_M2;
      end

      S_M2: begin
        dev_nxt   = nq_r - ss_r;
        state_nxt = S_M3;
      end

      S_M3: begin
        priority if (!any_r) begin
          cand = amcs_pkg::POL_FCFS;
        end else if (iorr_r) begin
          cand = amcs_pkg::POL_RR;
        end else if (n_r < NW'(2) || s_r == '0) begin
          cand = amcs_pkg::POL_FCFS;
        end else if (dev_w * DW'(25) < ss_w) begin
          cand = amcs_pkg::POL_FCFS;
        end else if ((dev_w << 2) > ss_w) begin
          cand = amcs_pkg::POL_SJF;
        end else begin
          cand = amcs_pkg::POL_RR;
        end
        // Hold window: take a change only once it has elapsed.
        if (cand != cur_mode_r &&
            {1'b0, now_r} >= ({1'b0, last_change_r} + 33'(hold_ticks_r))) begin
          cur_mode_nxt    = cand;
          last_change_nxt = now_r;
        end
        state_nxt = pass_r ? S_ACT : S_PRE;
      end

      S_PRE: begin
        // Swap in a strictly shorter eligible job.
        if (run_r && cur_mode_r == amcs_pkg::POL_SJF && job_r.length != 16'd0 &&
            lfound_r && ljob_r.length < job_r.length) begin
          mem_we    = 1'b1;
          mem_wa    = lidx_r[AW-1:0];
          mem_wd    = job_r;
          job_nxt   = ljob_r;
          event_nxt = amcs_pkg::EV_PREEMPT;
          slice_nxt = '0;
        end
        state_nxt = S_BR;
      end

      S_BR: begin
        priority if (!run_r || job_r.length == 16'd0) begin
          pass_nxt = 1'b1; xstat_nxt = 1'b0; xpick_nxt = 1'b0; rotate_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else if (cur_mode_r == amcs_pkg::POL_RR && slice_r >= time_slice_r) begin
          pass_nxt = 1'b1; xstat_nxt = 1'b1; xpick_nxt = 1'b1; rotate_nxt = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
        cnt_nxt = '0;
        any_nxt = 1'b0; n_nxt = '0; sio_nxt = '0; s_nxt = '0; q_nxt = '0;
        lfound_nxt = 1'b0; afound_nxt = 1'b0;
      end

      S_ACT: begin
        if (cur_mode_r == amcs_pkg::POL_SJF) begin
          pk_found = lfound_r; pk_idx = lidx_r; pk_job = ljob_r;
        end else begin
          pk_found = afound_r; pk_idx = aidx_r; pk_job = ajob_r;
        end
        slice_nxt = '0;
        if (!rotate_r) begin
          if (pk_found) begin
            job_nxt                     = pk_job;
            valid_nxt[pk_idx[AW-1:0]]   = 1'b0;
            run_nxt                     = 1'b1;
            event_nxt                   = amcs_pkg::EV_DISPATCH;
          end else begin
            run_nxt   = 1'b0;
            event_nxt = amcs_pkg::EV_NONE;
          end
        end else begin
          priority if (pk_found && pk_idx == IW'(D)) begin
            event_nxt = amcs_pkg::EV_ROTATE;
          end else if (pk_found) begin
            mem_we    = 1'b1;
            mem_wa    = pk_idx[AW-1:0];
            mem_wd    = job_r;
            job_nxt   = pk_job;
            event_nxt = amcs_pkg::EV_ROTATE;
          end else begin
            // Nothing eligible: park the job, or drop it when full.
            if (free_found) begin
              mem_we              = 1'b1;
              mem_wa              = free_idx;
              mem_wd              = job_r;
              valid_nxt[free_idx] = 1'b1;
            end else begin
              full_nxt = 1'b1;
            end
            run_nxt   = 1'b0;
            event_nxt = amcs_pkg::EV_NONE;
          end
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Fold one entry into the sums and the two running minima.
    if (p_en) begin
      if (p_stat) begin
        any_nxt = 1'b1;
        if (p_job.arrival <= now_r) begin
          n_nxt   = n_r + 1'b1;
          sio_nxt = sio_r + IOW'(p_job.io);
          s_nxt   = s_r + SW'(p_job.length);
          q_nxt   = q_r + QW'(32'(p_job.length) * 32'(p_job.length));
        end
      end
      if (p_pick && p_job.arrival <= now_r) begin
        if (!lfound_r || p_job.length < ljob_r.length) begin
          lfound_nxt = 1'b1; lidx_nxt = p_idx; ljob_nxt = p_job;
        end
        if (!afound_r || p_job.arrival < ajob_r.arrival) begin
          afound_nxt = 1'b1; aidx_nxt = p_idx; ajob_nxt = p_job;
        end
      end
    end

    if (emit) begin
      out_strobe_nxt         = 1'b1;
      out_nxt.mode           = cur_mode_nxt;
      out_nxt.event_res      = event_nxt;
      out_nxt.out_valid      = run_nxt;
      out_nxt.out_id         = run_nxt ? job_nxt.id      : 16'd0;
      out_nxt.out_arrival    = run_nxt ? job_nxt.arrival : 32'd0;
      out_nxt.out_length     = run_nxt ? job_nxt.length  : 16'd0;
      out_nxt.out_io_percent = run_nxt ? job_nxt.io      : 7'd0;
      out_nxt.table_full     = full_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      io_cutoff_r   <= amcs_pkg::IO_CUTOFF_RST;
      hold_ticks_r  <= amcs_pkg::HOLD_TICKS_RST;
      time_slice_r  <= amcs_pkg::TIME_SLICE_RST;
      valid_r       <= '0;
      cur_mode_r    <= amcs_pkg::POL_FCFS;
      last_change_r <= '0;
      slice_r       <= '0;
      out_strobe_r  <= 1'b0;
      cnt_r         <= '0;
      pipe_v_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      io_cutoff_r   <= io_cutoff_nxt;
      hold_ticks_r  <= hold_ticks_nxt;
      time_slice_r  <= time_slice_nxt;
      valid_r       <= valid_nxt;
      cur_mode_r    <= cur_mode_nxt;
      last_change_r <= last_change_nxt;
      slice_r       <= slice_nxt;
      out_strobe_r  <= out_strobe_nxt;
      cnt_r         <= cnt_nxt;
      pipe_v_r      <= pipe_v_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    run_r      <= run_nxt;
    job_r      <= job_nxt;
    now_r      <= now_nxt;
    event_r    <= event_nxt;
    full_r     <= full_nxt;
    pass_r     <= pass_nxt;
    xstat_r    <= xstat_nxt;
    xpick_r    <= xpick_nxt;
    rotate_r   <= rotate_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    any_r      <= any_nxt;
    n_r        <= n_nxt;
    sio_r      <= sio_nxt;
    s_r        <= s_nxt;
    q_r        <= q_nxt;
    lfound_r   <= lfound_nxt;
    lidx_r     <= lidx_nxt;
    ljob_r     <= ljob_nxt;
    afound_r   <= afound_nxt;
    aidx_r     <= aidx_nxt;
    ajob_r     <= ajob_nxt;
    nq_r       <= nq_nxt;
    ss_r       <= ss_nxt;
    dev_r      <= dev_nxt;
    iorr_r     <= iorr_nxt;
    out_r      <= out_nxt;
  end

endmodule

// ===== hdl/amcs_checker.sv =====
// Port-level checker for the adaptive mode cpu scheduler, bound to the top level.
// Depends on amcs_pkg and adaptive_mode_cpu_scheduler_top_macros.svh.
`include "adaptive_mode_cpu_scheduler_top_macros.svh"

module amcs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input amcs_pkg::in_item_t  in_data,
  input logic                out_strobe,
  input amcs_pkg::out_item_t out_data
);

  // An enqueue beat answers on the next cycle.
  `AMCS_ASSERT_NEXT(a_enq_answer, clk, rst_n, start && !busy && in_data.opcode == amcs_pkg::OP_ENQUEUE, out_strobe)
  // A tick beat occupies the block.
  `AMCS_ASSERT_NEXT(a_tick_busy, clk, rst_n, start && !busy && in_data.opcode == amcs_pkg::OP_TICK, busy)
  // An event always leaves a job on the cpu.
  `AMCS_ASSERT_NOW(a_event_run, clk, rst_n, out_strobe && out_data.event_res != amcs_pkg::EV_NONE, out_data.out_valid)
  // An idle cpu shows an empty job record.
  `AMCS_ASSERT_NOW(a_idle_zero, clk, rst_n, out_strobe && !out_data.out_valid, out_data.out_id == 16'd0 && out_data.out_length == 16'd0)
  // Mode is one of the three policies.
  `AMCS_ASSERT_NOW(a_mode_code, clk, rst_n, out_strobe, out_data.mode != 2'd3)

endmodule

bind adaptive_mode_cpu_scheduler_top amcs_checker u_amcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
